[hdl/fbd_pkg.sv]
// ----------------------------------------------------------------------------
// fbd_pkg - shared types and constants of the fixed band detector
// Field widths, register indexes and the structs passed between stages.
// ----------------------------------------------------------------------------
package fbd_pkg;

  // frame size limits
  localparam int unsigned MAX_WIDTH  = 8192;
  localparam int unsigned MAX_HEIGHT = 8192;

  // field widths
  localparam int unsigned PIX_W    = 24;
  localparam int unsigned SIZE_W   = 14;
  localparam int unsigned ROWS_W   = 13;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned AGREE_W  = 8;
  localparam int unsigned COUNT_W  = 27;
  localparam int unsigned TOTAL_W  = 28;
  localparam int unsigned PROD_W   = 45;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CDATA_W  = 17;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_TOP_ROWS     = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOTTOM_ROWS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_THRESHOLD    = 3'd4;
  localparam logic [IDX_W-1:0] REG_CONFIRM      = 3'd5;

  // register reset values
  localparam logic [SIZE_W-1:0]  RST_WIDTH     = 14'd1;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT    = 14'd1;
  localparam logic [THR_W-1:0]   RST_THRESHOLD = 17'd65536;
  localparam logic [AGREE_W-1:0] RST_CONFIRM   = 8'd3;
  localparam logic [AGREE_W-1:0] MIN_CONFIRM   = 8'd3;

  // settled configuration as seen by the datapath
  typedef struct packed {
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [ROWS_W-1:0]  top_rows;
    logic [ROWS_W-1:0]  bottom_rows;
    logic [SIZE_W-1:0]  center_rows;
    logic               geom_err;
    logic [THR_W-1:0]   threshold;
    logic [AGREE_W-1:0] need;
  } fbd_cfg_t;

  // equal counts of one finished frame
  typedef struct packed {
    logic [COUNT_W-1:0] top_eq;
    logic [COUNT_W-1:0] ctr_eq;
    logic [COUNT_W-1:0] bot_eq;
    logic               geom_err;
  } fbd_counts_t;

  // counts with the scaled threshold of each region
  typedef struct packed {
    fbd_counts_t       counts;
    logic [PROD_W-1:0] prod_top;
    logic [PROD_W-1:0] prod_ctr;
    logic [PROD_W-1:0] prod_bot;
  } fbd_prod_t;

endpackage

[hdl/fbd_counter.sv]
// ----------------------------------------------------------------------------
// fbd_counter - input register, raster position and equal-pixel counters
// Registers each pixel pair, sorts equal pixels into top, centre and bottom
// counts and hands the counts on at the last pixel of every frame.
// ----------------------------------------------------------------------------
module fbd_counter
  import fbd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fbd_cfg_t              cfg_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // previous_pixel, current_pixel
  output logic                  ev_valid_o,
  input  logic                  ev_ready_i,
  output fbd_counts_t           ev_o
);

  logic              in_valid_q;
  logic [PIX_W-1:0]  prev_q, cur_q;
  logic [POS_W-1:0]  col_q, row_q;
  logic [COUNT_W-1:0] top_eq_q, ctr_eq_q, bot_eq_q;
  logic              ev_valid_q;
  fbd_counts_t       ev_q;

  logic               process;
  logic               pix_eq, in_top, in_bot;
  logic               col_last, row_last, frame_last;
  logic [COUNT_W-1:0] top_sum, ctr_sum, bot_sum;

  // stage control: the held item moves on unless a frame event is stuck
  assign process       = in_valid_q && (!ev_valid_q || ev_ready_i);
  assign s_axis_tready = !in_valid_q || process;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      prev_q <= s_axis_tdata[PIX_W-1:0];
      cur_q  <= s_axis_tdata[2*PIX_W-1:PIX_W];
    end
  end

  // region of the pixel and updated counts
  always_comb begin
    pix_eq     = (prev_q == cur_q);
    in_top     = (row_q < cfg_i.top_rows);
    in_bot     = ({1'b0, row_q} + {1'b0, cfg_i.bottom_rows}) >= cfg_i.height;
    top_sum    = top_eq_q + COUNT_W'(pix_eq && in_top);
    bot_sum    = bot_eq_q + COUNT_W'(pix_eq && !in_top && in_bot);
    ctr_sum    = ctr_eq_q + COUNT_W'(pix_eq && !in_top && !in_bot);
    col_last   = ({1'b0, col_q} + 14'd1) >= cfg_i.width;
    row_last   = ({1'b0, row_q} + 14'd1) >= cfg_i.height;
    frame_last = col_last && row_last;
  end

  // position and counters, cleared at every frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      top_eq_q <= '0;
      ctr_eq_q <= '0;
      bot_eq_q <= '0;
    end else if (process) begin
      col_q <= col_last ? '0 : col_q + POS_W'(1);
      if (col_last) begin
        row_q <= row_last ? '0 : row_q + POS_W'(1);
      end
      if (frame_last) begin
        top_eq_q <= '0;
        ctr_eq_q <= '0;
        bot_eq_q <= '0;
      end else begin
        top_eq_q <= top_sum;
        ctr_eq_q <= ctr_sum;
        bot_eq_q <= bot_sum;
      end
    end
  end

  // frame event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (!ev_valid_q || ev_ready_i) begin
      ev_valid_q <= process && frame_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && frame_last) begin
      ev_q.top_eq   <= top_sum;
      ev_q.ctr_eq   <= ctr_sum;
      ev_q.bot_eq   <= bot_sum;
      ev_q.geom_err <= cfg_i.geom_err;
    end
  end

  assign ev_valid_o = ev_valid_q;
  assign ev_o       = ev_q;

endmodule

[hdl/fbd_ratio.sv]
// ----------------------------------------------------------------------------
// fbd_ratio - two-stage threshold scaling of the region pixel totals
// Stage one forms rows times width per region, stage two multiplies each
// total by the Q1.16 threshold for the cross-multiplied ratio test.
// ----------------------------------------------------------------------------
module fbd_ratio
  import fbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fbd_cfg_t    cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  fbd_counts_t in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output fbd_prod_t   out_o
);

  logic               v1_q, v2_q;
  logic               ready1, ready2;
  fbd_counts_t        cnt1_q;
  logic [TOTAL_W-1:0] tot_top_q, tot_ctr_q, tot_bot_q;
  fbd_prod_t          out_q;
  logic [PROD_W-1:0]  thr_x;

  assign ready2     = !v2_q || out_ready_i;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;
  assign thr_x      = PROD_W'(cfg_i.threshold);

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  // stage one: pixels per region
  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready1) begin
      cnt1_q    <= in_i;
      tot_top_q <= TOTAL_W'(cfg_i.top_rows) * TOTAL_W'(cfg_i.width);
      tot_ctr_q <= TOTAL_W'(cfg_i.center_rows) * TOTAL_W'(cfg_i.width);
      tot_bot_q <= TOTAL_W'(cfg_i.bottom_rows) * TOTAL_W'(cfg_i.width);
    end
  end

  // stage two: threshold times total
  always_ff @(posedge clk_i) begin
    if (v1_q && ready2) begin
      out_q.counts   <= cnt1_q;
      out_q.prod_top <= thr_x * PROD_W'(tot_top_q);
      out_q.prod_ctr <= thr_x * PROD_W'(tot_ctr_q);
      out_q.prod_bot <= thr_x * PROD_W'(tot_bot_q);
    end
  end

  assign out_valid_o = v2_q;
  assign out_o       = out_q;

endmodule

[hdl/fbd_band.sv]
// ----------------------------------------------------------------------------
// fbd_band - ratio compare, band agreement state and result register
// Decides centre movement and band stillness, updates agreement counts and
// confirmation latches and holds the frame result for the output stream.
// ----------------------------------------------------------------------------
module fbd_band
  import fbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fbd_cfg_t               cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  fbd_prod_t              in_i,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // top_agreements, bottom_agreements, top_confirmed, bottom_confirmed,
  // center_moved, geometry_error, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] res_q;
  logic [AGREE_W-1:0]     top_agree_q, bot_agree_q, top_agree_d, bot_agree_d;
  logic                   top_lat_q, bot_lat_q, top_lat_d, bot_lat_d;
  logic                   take, moved, top_still, bot_still;
  logic [PROD_W-1:0]      lhs_top, lhs_ctr, lhs_bot;

  assign in_ready_o = !out_valid_q || m_axis_tready;
  assign take       = in_valid_i && in_ready_o;

  // cross-multiplied ratio tests and band update
  always_comb begin
    lhs_top   = {2'b00, in_i.counts.top_eq, {FRAC_W{1'b0}}};
    lhs_ctr   = {2'b00, in_i.counts.ctr_eq, {FRAC_W{1'b0}}};
    lhs_bot   = {2'b00, in_i.counts.bot_eq, {FRAC_W{1'b0}}};
    moved     = !in_i.counts.geom_err && (lhs_ctr < in_i.prod_ctr);
    top_still = lhs_top >= in_i.prod_top;
    bot_still = lhs_bot >= in_i.prod_bot;

    top_agree_d = top_agree_q;
    top_lat_d   = top_lat_q;
    if (!in_i.counts.geom_err && !top_lat_q && (cfg_i.top_rows != '0)) begin
      top_agree_d = (top_still && moved) ? top_agree_q + AGREE_W'(1) : '0;
      top_lat_d   = top_agree_d >= cfg_i.need;
    end

    bot_agree_d = bot_agree_q;
    bot_lat_d   = bot_lat_q;
    if (!in_i.counts.geom_err && !bot_lat_q && (cfg_i.bottom_rows != '0)) begin
      bot_agree_d = (bot_still && moved) ? bot_agree_q + AGREE_W'(1) : '0;
      bot_lat_d   = bot_agree_d >= cfg_i.need;
    end
  end

  // band state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_agree_q <= '0;
      bot_agree_q <= '0;
      top_lat_q   <= 1'b0;
      bot_lat_q   <= 1'b0;
    end else if (take) begin
      top_agree_q <= top_agree_d;
      bot_agree_q <= bot_agree_d;
      top_lat_q   <= top_lat_d;
      bot_lat_q   <= bot_lat_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= {4'b0000, in_i.counts.geom_err, moved, bot_lat_d, top_lat_d,
                bot_agree_d, top_agree_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

endmodule

[hdl/fixed_band_detector.sv]
// ----------------------------------------------------------------------------
// fixed_band_detector - fixed header and footer band detection
// Compares co-located pixels of two frames and confirms still bands.
// ----------------------------------------------------------------------------
// Pixel pairs enter on the s_axis channel in raster order, one item per
// clock when the stream allows. Items that are not the last pixel of a
// frame produce nothing; the last pixel of each frame produces one result
// item on m_axis with the band agreement counts, confirmation flags, the
// centre movement flag and the geometry error flag.
// Configuration registers are written through the cfg channel, which is
// always ready; write them only while no frame result is outstanding.
// Throughput is one pixel per clock while m_axis holds no input back.
// A frame result passes the input register, counter stage, two multiply
// stages for the threshold scaling, then the result register.
// Every stage has its own valid bit, so a stalled m_axis only holds back
// input once the frame results queued behind the output fill the stages;
// pixels that are not frame ends keep flowing until then.
// Reset clears the position, equal counts, agreement counts and latches
// and loads the register defaults (1 x 1 frame, no bands, threshold 1.0,
// three confirmations).
// ----------------------------------------------------------------------------
module fixed_band_detector
  import fbd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // previous_pixel [23:0], current_pixel [47:24]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // top_agreements [7:0], bottom_agreements [15:8], top_confirmed [16],
  // bottom_confirmed [17], center_moved [18], geometry_error [19], zeros
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IDX_W-1:0]       cfg_addr_i,
  input  logic [CDATA_W-1:0]     cfg_data_i
);

  logic [SIZE_W-1:0]  width_q, height_q;
  logic [ROWS_W-1:0]  top_rows_q, bot_rows_q;
  logic [THR_W-1:0]   thr_q;
  logic [AGREE_W-1:0] confirm_q;
  fbd_cfg_t           cfg;
  logic [SIZE_W-1:0]  band_sum;

  logic        ev_valid, ev_ready, pr_valid, pr_ready;
  fbd_counts_t ev;
  fbd_prod_t   pr;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= RST_WIDTH;
      height_q   <= RST_HEIGHT;
      top_rows_q <= '0;
      bot_rows_q <= '0;
      thr_q      <= RST_THRESHOLD;
      confirm_q  <= RST_CONFIRM;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_FRAME_WIDTH:  width_q    <= cfg_data_i[SIZE_W-1:0];
        REG_FRAME_HEIGHT: height_q   <= cfg_data_i[SIZE_W-1:0];
        REG_TOP_ROWS:     top_rows_q <= cfg_data_i[ROWS_W-1:0];
        REG_BOTTOM_ROWS:  bot_rows_q <= cfg_data_i[ROWS_W-1:0];
        REG_THRESHOLD:    thr_q      <= cfg_data_i[THR_W-1:0];
        REG_CONFIRM:      confirm_q  <= cfg_data_i[AGREE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes and band geometry
  always_comb begin
    if (width_q == '0) begin
      cfg.width = SIZE_W'(1);
    end else if (width_q > SIZE_W'(MAX_WIDTH)) begin
      cfg.width = SIZE_W'(MAX_WIDTH);
    end else begin
      cfg.width = width_q;
    end
    if (height_q == '0) begin
      cfg.height = SIZE_W'(1);
    end else if (height_q > SIZE_W'(MAX_HEIGHT)) begin
      cfg.height = SIZE_W'(MAX_HEIGHT);
    end else begin
      cfg.height = height_q;
    end
    band_sum        = {1'b0, top_rows_q} + {1'b0, bot_rows_q};
    cfg.top_rows    = top_rows_q;
    cfg.bottom_rows = bot_rows_q;
    cfg.geom_err    = band_sum >= cfg.height;
    cfg.center_rows = cfg.height - band_sum;
    cfg.threshold   = thr_q;
    cfg.need        = (confirm_q < MIN_CONFIRM) ? MIN_CONFIRM : confirm_q;
  end

  fbd_counter u_counter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .ev_valid_o    (ev_valid),
    .ev_ready_i    (ev_ready),
    .ev_o          (ev)
  );

  fbd_ratio u_ratio (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (ev_valid),
    .in_ready_o  (ev_ready),
    .in_i        (ev),
    .out_valid_o (pr_valid),
    .out_ready_i (pr_ready),
    .out_o       (pr)
  );

  fbd_band u_band (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (pr_valid),
    .in_ready_o    (pr_ready),
    .in_i          (pr),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
